/* hdl/tnf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuned note to frequency: shared definitions
// Command codes, fixed-point constants, Q30 pitch tables and the pipeline
// stage record used by the frequency datapath.
// ----------------------------------------------------------------------------
package tnf_pkg;

   localparam int FREQ_FRACTION_BITS = 16;
   localparam int FREQ_WIDTH         = 31;

   localparam int PITCH_CLASSES  = 12;
   localparam int CENTS_LIMIT    = 1200;
   localparam int OCTAVE_MAX     = 10;
   localparam int NOTE_MAX       = 127;
   localparam int RESET_NOTE     = 72;
   localparam int RESET_OCTAVE   = 6;

   localparam int A4_NOTE        = 69;
   localparam int A4_HZ          = 440;
   localparam int SEMITONE_CENTS = 100;
   localparam int OCTAVE_CENTS   = 1200;
   localparam int OCTAVE_BIAS    = 8;
   localparam int POS_OFFSET     = OCTAVE_BIAS * OCTAVE_CENTS - A4_NOTE * SEMITONE_CENTS;

   localparam int Q30_BITS       = 30;
   localparam int SHIFT_BASE     = Q30_BITS + OCTAVE_BIAS - FREQ_FRACTION_BITS;

   // reciprocal multipliers for constant division
   localparam int DIV12_SHIFT    = 9;
   localparam int DIV12_MUL      = (2 ** DIV12_SHIFT + PITCH_CLASSES - 1) / PITCH_CLASSES;
   localparam int DIV1200_SHIFT  = 26;
   localparam int DIV1200_MUL    = (2 ** DIV1200_SHIFT + OCTAVE_CENTS - 1) / OCTAVE_CENTS;
   localparam int DIV100_SHIFT   = 17;
   localparam int DIV100_MUL     = (2 ** DIV100_SHIFT + SEMITONE_CENTS - 1) / SEMITONE_CENTS;

   // hue: (h * 65536 + 1200) / 2400 == (h * 2048 + 37) / 75
   localparam int HUE_SPAN       = 2400;
   localparam int HUE_CLASS_STEP = HUE_SPAN / PITCH_CLASSES;
   localparam int HUE_Y_SHIFT    = 11;
   localparam int HUE_DIVISOR    = 75;
   localparam int HUE_ROUND      = HUE_DIVISOR / 2;
   localparam int HUE_DIV_SHIFT  = 30;
   localparam int HUE_DIV_MUL    = (2 ** HUE_DIV_SHIFT + HUE_DIVISOR - 1) / HUE_DIVISOR;

   localparam logic [PITCH_CLASSES-1:0] WHITE_KEY_MASK = 12'b1010_1011_0101;

   localparam int CENT_BITS = 7;

   localparam logic [63:0] Q30_SCALE = 64'd1073741824;
   localparam logic [63:0] Q30_HALF  = 64'd500000000;
   localparam logic [63:0] Q30_DEN   = 64'd1000000000;

   localparam logic [30:0] SEMITONE_Q30 [PITCH_CLASSES] = '{
      31'((64'd1000000000 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1059463094 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1122462048 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1189207115 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1259921050 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1334839854 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1414213562 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1498307077 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1587401052 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1681792831 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1781797436 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1887748625 * Q30_SCALE + Q30_HALF) / Q30_DEN)
   };

   localparam logic [30:0] CENTBIT_Q30 [CENT_BITS] = '{
      31'((64'd1000577790 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1001155913 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1002313162 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1004631674 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1009284801 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1018655810 * Q30_SCALE + Q30_HALF) / Q30_DEN),
      31'((64'd1037659659 * Q30_SCALE + Q30_HALF) / Q30_DEN)
   };

   typedef enum logic [2:0] {
      CMD_PLAY_NOTE    = 3'd0,
      CMD_SET_CENTS    = 3'd1,
      CMD_SELECT_CLASS = 3'd2,
      CMD_SET_OCTAVE   = 3'd3,
      CMD_RETUNE_CLASS = 3'd4
   } command_type;

   // pipeline stage positions
   localparam int ST_SNAP    = 0;
   localparam int ST_POS     = 1;
   localparam int ST_QUOT    = 2;
   localparam int ST_REM     = 3;
   localparam int ST_SEMI    = 4;
   localparam int ST_CENT    = 5;
   localparam int ST_MUL0    = 6;
   localparam int ST_PROD    = ST_MUL0 + CENT_BITS;
   localparam int ST_OUT     = ST_PROD + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef struct packed {
      logic [6:0]            note;
      logic [3:0]            pitch_class;
      logic [3:0]            octave;
      logic [11:0]           cents;
      logic                  white;
      logic [22:0]           hue_y;
      logic [15:0]           hue;
      logic [14:0]           pos;
      logic [3:0]            quot;
      logic [10:0]           rem;
      logic [3:0]            semi;
      logic [6:0]            cent_rem;
      logic [30:0]           mant;
      logic [39:0]           prod;
      logic [FREQ_WIDTH-1:0] freq;
   } stage_type;

   function automatic logic [6:0] note_of_class(input logic [3:0] pc, input logic [3:0] oct);
      logic [7:0] n;
      n = 8'(pc) + 8'(oct) * 8'(PITCH_CLASSES);
      return (n > 8'(NOTE_MAX)) ? 7'(NOTE_MAX) : n[6:0];
   endfunction

endpackage

/* hdl/tuned_note_to_frequency_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuned note to frequency unit
// Holds the current note and a per-pitch-class cents table, applies one
// command per transaction and returns the equal-tempered frequency in fixed
// point together with note, class, octave, cents, key colour and hue.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall command, note, amount
//   rsp      out        rsp_valid/rsp_stall frequency_q16, midi_note, pitch_class,
//                                           octave_now, cents_now, white_key, hue_q16
//
// One transaction enters per cycle while req_stall is low; each result is
// offered after 15 register stages, the first loading at the edge that accepts
// its request: state update, five for the cents split, seven cent-bit Q30
// multiplies (one multiplier each) and two for final scaling.
// Reset clears the pipeline, the tuning table to zero and the note to 72.
// A stalled result holds the output stage; earlier stages keep filling
// bubbles, and req_stall rises once every stage is occupied.
// ----------------------------------------------------------------------------
module tuned_note_to_frequency_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [2:0]                            req_command,
   input  logic [6:0]                            req_note,
   input  logic signed [11:0]                    req_amount,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tnf_pkg::FREQ_WIDTH-1:0]        rsp_frequency_q16,
   output logic [6:0]                            rsp_midi_note,
   output logic [3:0]                            rsp_pitch_class,
   output logic [3:0]                            rsp_octave_now,
   output logic signed [11:0]                    rsp_cents_now,
   output logic                                  rsp_white_key,
   output logic [15:0]                           rsp_hue_q16
);

   localparam int N = tnf_pkg::NUM_STAGES;
   localparam logic signed [11:0] CENTS_HI = 12'(tnf_pkg::CENTS_LIMIT);
   localparam logic signed [11:0] CENTS_LO = -12'(tnf_pkg::CENTS_LIMIT);

   tnf_pkg::command_type cmd;
   logic                 req_accept;
   logic                 class_ok;
   logic signed [11:0]   amount_clamped;
   logic [3:0]           octave_clamped;
   logic [12:0]          note_div_prod;
   logic [3:0]           note_octave;
   logic [3:0]           note_class;

   logic [6:0]           cur_note_ff,   cur_note_in;
   logic [3:0]           cur_class_ff,  cur_class_in;
   logic [3:0]           cur_octave_ff, cur_octave_in;
   logic signed [11:0]   cur_cents_ff,  cur_cents_in;
   logic signed [11:0]   tuning_ff [tnf_pkg::PITCH_CLASSES];
   logic signed [11:0]   tuning_in [tnf_pkg::PITCH_CLASSES];

   tnf_pkg::stage_type   stage_ff [N];
   tnf_pkg::stage_type   stage_in [N];
   logic [N-1:0]         valid_ff;
   logic [N-1:0]         valid_in;
   logic [N-1:0]         stage_ready;

   logic [15:0]          pos_sum;
   logic [13:0]          hue_raw;
   logic [11:0]          hue_wrap;
   logic [30:0]          quot_prod;
   logic [46:0]          hue_prod;
   logic [14:0]          rem_full;
   logic [21:0]          semi_prod;
   logic [10:0]          cent_full;
   logic [61:0]          mul_full [tnf_pkg::CENT_BITS];
   logic [5:0]           out_shift;
   logic [40:0]          round_sum;

   assign cmd        = tnf_pkg::command_type'(req_command);
   assign req_stall  = !stage_ready[0];
   assign req_accept = req_valid && !req_stall;
   assign class_ok   = req_note < 7'(tnf_pkg::PITCH_CLASSES);

   always_comb begin
      if (req_amount > CENTS_HI) begin
         amount_clamped = CENTS_HI;
      end else if (req_amount < CENTS_LO) begin
         amount_clamped = CENTS_LO;
      end else begin
         amount_clamped = req_amount;
      end
   end

   always_comb begin
      if (req_amount[11]) begin
         octave_clamped = '0;
      end else if (req_amount[10:0] > 11'(tnf_pkg::OCTAVE_MAX)) begin
         octave_clamped = 4'(tnf_pkg::OCTAVE_MAX);
      end else begin
         octave_clamped = req_amount[3:0];
      end
   end

   assign note_div_prod = 13'(req_note) * 13'(tnf_pkg::DIV12_MUL);
   assign note_octave   = note_div_prod[12:tnf_pkg::DIV12_SHIFT];
   assign note_class    = 4'(req_note - 7'(note_octave) * 7'(tnf_pkg::PITCH_CLASSES));

   // command decode and state update
   always_comb begin
      cur_note_in   = cur_note_ff;
      cur_class_in  = cur_class_ff;
      cur_octave_in = cur_octave_ff;
      cur_cents_in  = cur_cents_ff;
      tuning_in     = tuning_ff;
      unique case (cmd)
         tnf_pkg::CMD_PLAY_NOTE: begin
            cur_note_in   = req_note;
            cur_class_in  = note_class;
            cur_octave_in = note_octave;
            cur_cents_in  = amount_clamped;
         end
         tnf_pkg::CMD_SET_CENTS: begin
            cur_cents_in = amount_clamped;
         end
         tnf_pkg::CMD_SELECT_CLASS: begin
            if (class_ok) begin
               cur_class_in = req_note[3:0];
               cur_cents_in = tuning_ff[req_note[3:0]];
               cur_note_in  = tnf_pkg::note_of_class(req_note[3:0], cur_octave_ff);
            end
         end
         tnf_pkg::CMD_SET_OCTAVE: begin
            cur_octave_in = octave_clamped;
            cur_note_in   = tnf_pkg::note_of_class(cur_class_ff, octave_clamped);
         end
         tnf_pkg::CMD_RETUNE_CLASS: begin
            if (class_ok) begin
               tuning_in[req_note[3:0]] = amount_clamped;
               if (req_note[3:0] == cur_class_ff) begin
                  cur_cents_in = amount_clamped;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_note_ff   <= 7'(tnf_pkg::RESET_NOTE);
         cur_class_ff  <= '0;
         cur_octave_ff <= 4'(tnf_pkg::RESET_OCTAVE);
         cur_cents_ff  <= '0;
         for (int i = 0; i < tnf_pkg::PITCH_CLASSES; i++) begin
            tuning_ff[i] <= '0;
         end
      end else if (req_accept) begin
         cur_note_ff   <= cur_note_in;
         cur_class_ff  <= cur_class_in;
         cur_octave_ff <= cur_octave_in;
         cur_cents_ff  <= cur_cents_in;
         tuning_ff     <= tuning_in;
      end
   end

   // datapath arithmetic per stage
   assign pos_sum   = 16'(stage_ff[tnf_pkg::ST_SNAP].note) * 16'(tnf_pkg::SEMITONE_CENTS)
                    + {{4{stage_ff[tnf_pkg::ST_SNAP].cents[11]}},
                       stage_ff[tnf_pkg::ST_SNAP].cents}
                    + 16'(tnf_pkg::POS_OFFSET);
   assign hue_raw   = 14'(stage_ff[tnf_pkg::ST_SNAP].pitch_class)
                      * 14'(tnf_pkg::HUE_CLASS_STEP)
                    + {{2{stage_ff[tnf_pkg::ST_SNAP].cents[11]}},
                       stage_ff[tnf_pkg::ST_SNAP].cents}
                    + 14'(tnf_pkg::HUE_SPAN);

   always_comb begin
      if (hue_raw >= 14'(2 * tnf_pkg::HUE_SPAN)) begin
         hue_wrap = 12'(hue_raw - 14'(2 * tnf_pkg::HUE_SPAN));
      end else if (hue_raw >= 14'(tnf_pkg::HUE_SPAN)) begin
         hue_wrap = 12'(hue_raw - 14'(tnf_pkg::HUE_SPAN));
      end else begin
         hue_wrap = hue_raw[11:0];
      end
   end

   assign quot_prod = 31'(stage_ff[tnf_pkg::ST_POS].pos) * 31'(tnf_pkg::DIV1200_MUL);
   assign hue_prod  = 47'(stage_ff[tnf_pkg::ST_POS].hue_y) * 47'(tnf_pkg::HUE_DIV_MUL);
   assign rem_full  = stage_ff[tnf_pkg::ST_QUOT].pos
                    - 15'(stage_ff[tnf_pkg::ST_QUOT].quot) * 15'(tnf_pkg::OCTAVE_CENTS);
   assign semi_prod = 22'(stage_ff[tnf_pkg::ST_REM].rem) * 22'(tnf_pkg::DIV100_MUL);
   assign cent_full = stage_ff[tnf_pkg::ST_SEMI].rem
                    - 11'(stage_ff[tnf_pkg::ST_SEMI].semi) * 11'(tnf_pkg::SEMITONE_CENTS);

   always_comb begin
      for (int b = 0; b < tnf_pkg::CENT_BITS; b++) begin
         mul_full[b] = 62'(stage_ff[tnf_pkg::ST_MUL0 + b - 1].mant)
                       * 62'(tnf_pkg::CENTBIT_Q30[b])
                     + (62'(1) << (tnf_pkg::Q30_BITS - 1));
      end
   end

   assign out_shift = 6'(tnf_pkg::SHIFT_BASE) - 6'(stage_ff[tnf_pkg::ST_PROD].quot);
   assign round_sum = {1'b0, stage_ff[tnf_pkg::ST_PROD].prod}
                    + (41'(1) << (out_shift - 6'd1));

   always_comb begin
      stage_in[tnf_pkg::ST_SNAP]             = '0;
      stage_in[tnf_pkg::ST_SNAP].note        = cur_note_in;
      stage_in[tnf_pkg::ST_SNAP].pitch_class = cur_class_in;
      stage_in[tnf_pkg::ST_SNAP].octave      = cur_octave_in;
      stage_in[tnf_pkg::ST_SNAP].cents       = cur_cents_in;

      stage_in[tnf_pkg::ST_POS]       = stage_ff[tnf_pkg::ST_SNAP];
      stage_in[tnf_pkg::ST_POS].pos   = pos_sum[14:0];
      stage_in[tnf_pkg::ST_POS].white =
         tnf_pkg::WHITE_KEY_MASK[stage_ff[tnf_pkg::ST_SNAP].pitch_class];
      stage_in[tnf_pkg::ST_POS].hue_y = {hue_wrap, 11'd0} + 23'(tnf_pkg::HUE_ROUND);

      stage_in[tnf_pkg::ST_QUOT]      = stage_ff[tnf_pkg::ST_POS];
      stage_in[tnf_pkg::ST_QUOT].quot = quot_prod[tnf_pkg::DIV1200_SHIFT +: 4];
      stage_in[tnf_pkg::ST_QUOT].hue  = hue_prod[tnf_pkg::HUE_DIV_SHIFT +: 16];

      stage_in[tnf_pkg::ST_REM]     = stage_ff[tnf_pkg::ST_QUOT];
      stage_in[tnf_pkg::ST_REM].rem = rem_full[10:0];

      stage_in[tnf_pkg::ST_SEMI]      = stage_ff[tnf_pkg::ST_REM];
      stage_in[tnf_pkg::ST_SEMI].semi = semi_prod[tnf_pkg::DIV100_SHIFT +: 4];

      stage_in[tnf_pkg::ST_CENT]          = stage_ff[tnf_pkg::ST_SEMI];
      stage_in[tnf_pkg::ST_CENT].cent_rem = cent_full[6:0];
      stage_in[tnf_pkg::ST_CENT].mant     =
         tnf_pkg::SEMITONE_Q30[stage_ff[tnf_pkg::ST_SEMI].semi];

      for (int b = 0; b < tnf_pkg::CENT_BITS; b++) begin
         stage_in[tnf_pkg::ST_MUL0 + b] = stage_ff[tnf_pkg::ST_MUL0 + b - 1];
         if (stage_ff[tnf_pkg::ST_MUL0 + b - 1].cent_rem[b]) begin
            stage_in[tnf_pkg::ST_MUL0 + b].mant = mul_full[b][60:30];
         end
      end

      stage_in[tnf_pkg::ST_PROD]      = stage_ff[tnf_pkg::ST_PROD - 1];
      stage_in[tnf_pkg::ST_PROD].prod = 40'(stage_ff[tnf_pkg::ST_PROD - 1].mant)
                                        * 40'(tnf_pkg::A4_HZ);

      stage_in[tnf_pkg::ST_OUT]      = stage_ff[tnf_pkg::ST_PROD];
      stage_in[tnf_pkg::ST_OUT].freq = tnf_pkg::FREQ_WIDTH'(round_sum >> out_shift);
   end

   // a stage may load when it or any stage after it is empty, or the output moves
   always_comb begin
      for (int k = 0; k < N; k++) begin
         stage_ready[k] = !rsp_stall || (((~valid_ff) >> k) != '0);
      end
   end

   assign valid_in = {valid_ff[N-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (stage_ready[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign rsp_valid         = valid_ff[tnf_pkg::ST_OUT];
   assign rsp_frequency_q16 = stage_ff[tnf_pkg::ST_OUT].freq;
   assign rsp_midi_note     = stage_ff[tnf_pkg::ST_OUT].note;
   assign rsp_pitch_class   = stage_ff[tnf_pkg::ST_OUT].pitch_class;
   assign rsp_octave_now    = stage_ff[tnf_pkg::ST_OUT].octave;
   assign rsp_cents_now     = stage_ff[tnf_pkg::ST_OUT].cents;
   assign rsp_white_key     = stage_ff[tnf_pkg::ST_OUT].white;
   assign rsp_hue_q16       = stage_ff[tnf_pkg::ST_OUT].hue;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[tnf_pkg::ST_SNAP])
      else $error("accepted transaction did not enter the first stage");

   a_split_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[tnf_pkg::ST_CENT] |->
         stage_ff[tnf_pkg::ST_CENT].cent_rem < 7'(tnf_pkg::SEMITONE_CENTS)
         && stage_ff[tnf_pkg::ST_CENT].semi < 4'(tnf_pkg::PITCH_CLASSES))
      else $error("cents split out of range");

   a_note_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_midi_note == 7'(tnf_pkg::NOTE_MAX)
         || 8'(rsp_midi_note) == 8'(rsp_pitch_class)
            + 8'(rsp_octave_now) * 8'(tnf_pkg::PITCH_CLASSES))
      else $error("note does not match class and octave");

   a_state_bounds: assert property (@(posedge clock) disable iff (reset)
      cur_class_ff < 4'(tnf_pkg::PITCH_CLASSES)
      && cur_octave_ff <= 4'(tnf_pkg::OCTAVE_MAX)
      && cur_cents_ff <= CENTS_HI && cur_cents_ff >= CENTS_LO)
      else $error("current note state out of range");

endmodule

/* test/tuned_note_to_frequency_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuned note to frequency unit: testbench
// Drives note, cents, class, octave and retune commands through the request
// channel. Each accepted transaction updates a local model of the tuning
// table and the current note, which predicts the result. The predicted
// result is queued and compared field by field with every result the unit
// returns. Both channels idle at random. The result side also holds off for
// a long stretch so that the pipeline fills up, and the sender pauses until
// every result has come back.
// ----------------------------------------------------------------------------
module tuned_note_to_frequency_unit_test;

   localparam int HALF_PERIOD    = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 30;

   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   localparam longint unsigned SEMITONE_D9 [tnf_pkg::PITCH_CLASSES] = '{
      64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
      64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
      64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
   };
   localparam longint unsigned CENT_STEP_D9 [tnf_pkg::CENT_BITS] = '{
      64'd1000577790, 64'd1001155913, 64'd1002313162, 64'd1004631674,
      64'd1009284801, 64'd1018655810, 64'd1037659659
   };

   typedef struct {
      logic [tnf_pkg::FREQ_WIDTH-1:0] frequency;
      logic [6:0]                     note;
      logic [3:0]                     pitch_class;
      logic [3:0]                     octave;
      logic signed [11:0]             cents;
      logic                           white;
      logic [15:0]                    hue;
   } tone_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [2:0]                     req_command;
   logic [6:0]                     req_note;
   logic signed [11:0]             req_amount;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [tnf_pkg::FREQ_WIDTH-1:0] rsp_frequency_q16;
   logic [6:0]                     rsp_midi_note;
   logic [3:0]                     rsp_pitch_class;
   logic [3:0]                     rsp_octave_now;
   logic signed [11:0]             rsp_cents_now;
   logic                           rsp_white_key;
   logic [15:0]                    rsp_hue_q16;

   tone_type expected_tones [$];
   int    class_cents [tnf_pkg::PITCH_CLASSES];
   int    cur_note;
   int    cur_class;
   int    cur_octave;
   int    cur_cents;

   int send_gap_max  = 0;
   int recv_gap_max  = 0;
   bit hold_results  = 1'b0;
   int error_count   = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int quiet_cycles  = 0;
   int input_stall_cycles = 0;

   tuned_note_to_frequency_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_note          (req_note),
      .req_amount        (req_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frequency_q16 (rsp_frequency_q16),
      .rsp_midi_note     (rsp_midi_note),
      .rsp_pitch_class   (rsp_pitch_class),
      .rsp_octave_now    (rsp_octave_now),
      .rsp_cents_now     (rsp_cents_now),
      .rsp_white_key     (rsp_white_key),
      .rsp_hue_q16       (rsp_hue_q16)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic longint unsigned q30_of(input longint unsigned d9);
      return (d9 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
   endfunction

   function automatic int limit_cents(input int v);
      if (v > tnf_pkg::CENTS_LIMIT) return tnf_pkg::CENTS_LIMIT;
      if (v < -tnf_pkg::CENTS_LIMIT) return -tnf_pkg::CENTS_LIMIT;
      return v;
   endfunction

   function automatic void refresh_note();
      int n;
      n = cur_class + tnf_pkg::PITCH_CLASSES * cur_octave;
      cur_note = (n > tnf_pkg::NOTE_MAX) ? tnf_pkg::NOTE_MAX : n;
   endfunction

   function automatic logic [tnf_pkg::FREQ_WIDTH-1:0] frequency_q16_of(input int note,
                                                                       input int cents);
      int pos, oct, rem, semi, cent_part, shift, b;
      longint unsigned mant, scaled;
      pos       = (note - tnf_pkg::A4_NOTE) * 100 + cents + 9600;
      oct       = pos / 1200 - 8;
      rem       = pos % 1200;
      semi      = rem / 100;
      cent_part = rem % 100;
      mant      = q30_of(SEMITONE_D9[semi]);
      for (b = 0; b < tnf_pkg::CENT_BITS; b++) begin
         if (cent_part[b])
            mant = (mant * q30_of(CENT_STEP_D9[b]) + (64'd1 << 29)) >> 30;
      end
      shift  = 30 - tnf_pkg::FREQ_FRACTION_BITS - oct;
      scaled = (64'd440 * mant + (64'd1 << (shift - 1))) >> shift;
      return scaled[tnf_pkg::FREQ_WIDTH-1:0];
   endfunction

   function automatic void apply_command(input logic [2:0] cmd, input logic [6:0] note,
                                         input logic signed [11:0] amount);
      int amt;
      int nt;
      amt = int'(amount);
      nt  = int'(note);
      case (cmd)
         tnf_pkg::CMD_PLAY_NOTE: begin
            cur_note   = nt;
            cur_class  = nt % tnf_pkg::PITCH_CLASSES;
            cur_octave = nt / tnf_pkg::PITCH_CLASSES;
            cur_cents  = limit_cents(amt);
         end
         tnf_pkg::CMD_SET_CENTS: begin
            cur_cents = limit_cents(amt);
         end
         tnf_pkg::CMD_SELECT_CLASS: begin
            if (nt < tnf_pkg::PITCH_CLASSES) begin
               cur_class = nt;
               cur_cents = class_cents[nt];
               refresh_note();
            end
         end
         tnf_pkg::CMD_SET_OCTAVE: begin
            cur_octave = (amt < 0) ? 0 :
                         ((amt > tnf_pkg::OCTAVE_MAX) ? tnf_pkg::OCTAVE_MAX : amt);
            refresh_note();
         end
         tnf_pkg::CMD_RETUNE_CLASS: begin
            if (nt < tnf_pkg::PITCH_CLASSES) begin
               class_cents[nt] = limit_cents(amt);
               if (nt == cur_class) cur_cents = class_cents[nt];
            end
         end
         default: ;
      endcase
   endfunction

   function automatic tone_type current_tone();
      tone_type t;
      int h;
      h = (cur_class * 200 + cur_cents + 2400) % 2400;
      t.frequency   = frequency_q16_of(cur_note, cur_cents);
      t.note        = 7'(cur_note);
      t.pitch_class = 4'(cur_class);
      t.octave      = 4'(cur_octave);
      t.cents       = 12'(cur_cents);
      case (cur_class)
         1, 3, 6, 8, 10: t.white = 1'b0;
         default:        t.white = 1'b1;
      endcase
      t.hue = 16'((h * 65536 + 1200) / 2400);
      return t;
   endfunction

   function automatic logic signed [11:0] random_cents();
      int v;
      if ($urandom_range(0, 4) == 0) v = int'($urandom);
      else v = int'($urandom_range(0, 2400)) - tnf_pkg::CENTS_LIMIT;
      return v[11:0];
   endfunction

   task automatic send_command(input logic [2:0] cmd, input logic [6:0] note,
                               input logic signed [11:0] amount);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_note    <= note;
      req_amount  <= amount;
      do @(posedge clock); while (req_stall);
      apply_command(cmd, note, amount);
      expected_tones.push_back(current_tone());
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_random_command();
      int pick;
      logic [2:0] cmd;
      logic [6:0] note;
      logic signed [11:0] amount;
      pick   = $urandom_range(0, 99);
      note   = 7'($urandom);
      amount = random_cents();
      if (pick < 28) begin
         cmd = tnf_pkg::CMD_PLAY_NOTE;
      end else if (pick < 42) begin
         cmd = tnf_pkg::CMD_SET_CENTS;
      end else if (pick < 60) begin
         cmd = tnf_pkg::CMD_SELECT_CLASS;
         if ($urandom_range(0, 9) != 0)
            note = 7'($urandom_range(0, tnf_pkg::PITCH_CLASSES - 1));
      end else if (pick < 76) begin
         cmd = tnf_pkg::CMD_SET_OCTAVE;
         if ($urandom_range(0, 6) != 0)
            amount = 12'($urandom_range(0, tnf_pkg::OCTAVE_MAX));
      end else if (pick < 93) begin
         cmd = tnf_pkg::CMD_RETUNE_CLASS;
         if ($urandom_range(0, 9) != 0)
            note = 7'($urandom_range(0, tnf_pkg::PITCH_CLASSES - 1));
      end else begin
         cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end
      send_command(cmd, note, amount);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (expected_tones.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic check_field(input string label, input longint want, input longint got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   task automatic test_reset_state();
      send_gap_max = 0;
      recv_gap_max = 0;
      send_command(CMD_SPARE_FIRST, 7'd0, 12'sd0);
   endtask

   task automatic test_directed_cases();
      send_gap_max = 11;
      recv_gap_max = 11;
      send_command(tnf_pkg::CMD_PLAY_NOTE, 7'd0, -12'sd1200);
      send_command(tnf_pkg::CMD_PLAY_NOTE, 7'd127, 12'sd1200);
      send_command(tnf_pkg::CMD_PLAY_NOTE, 7'd127, 12'sh800);
      send_command(tnf_pkg::CMD_PLAY_NOTE, 7'd0, 12'sd2047);
      send_command(tnf_pkg::CMD_PLAY_NOTE, 7'd69, 12'sd63);
      send_command(tnf_pkg::CMD_PLAY_NOTE, 7'd69, 12'sd99);
      send_command(tnf_pkg::CMD_SET_CENTS, 7'd127, -12'sd1201);
      send_command(tnf_pkg::CMD_SET_CENTS, 7'd0, 12'sd1200);
      send_command(tnf_pkg::CMD_SELECT_CLASS, 7'd11, 12'sd0);
      send_command(tnf_pkg::CMD_RETUNE_CLASS, 7'd11, 12'sd1500);
      send_command(tnf_pkg::CMD_RETUNE_CLASS, 7'd3, 12'sh800);
      send_command(tnf_pkg::CMD_SELECT_CLASS, 7'd3, 12'sd0);
      send_command(tnf_pkg::CMD_SELECT_CLASS, 7'd11, 12'sd0);
      send_command(tnf_pkg::CMD_SET_OCTAVE, 7'd0, 12'sd10);
      send_command(tnf_pkg::CMD_SET_OCTAVE, 7'd127, -12'sd1);
      send_command(tnf_pkg::CMD_SET_OCTAVE, 7'd0, 12'sd2047);
      send_command(tnf_pkg::CMD_SELECT_CLASS, 7'd12, 12'sd0);
      send_command(tnf_pkg::CMD_SELECT_CLASS, 7'd127, -12'sd1);
      send_command(tnf_pkg::CMD_RETUNE_CLASS, 7'd127, 12'sd500);
      send_command(tnf_pkg::CMD_PLAY_NOTE, 7'd78, 12'sd1200);
      send_command(CMD_SPARE_MID, 7'd0, 12'sd0);
      send_command(CMD_SPARE_LAST, 7'd127, -12'sd1);
   endtask

   task automatic test_random_traffic(input int count, input int send_max, input int recv_max);
      send_gap_max = send_max;
      recv_gap_max = recv_max;
      repeat (count) send_random_command();
   endtask

   task automatic test_result_backpressure();
      send_gap_max = 0;
      recv_gap_max = 11;
      hold_results = 1'b1;
      repeat (60) send_random_command();
      pause_until_drained();
   endtask

   task automatic test_drain_pauses();
      send_gap_max = 5;
      recv_gap_max = 5;
      repeat (6) begin
         repeat ($urandom_range(1, 20)) send_random_command();
         pause_until_drained();
      end
   endtask

   // result side: random stall per transaction, long hold when asked
   initial begin
      int wait_cycles;
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_results) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_results = 1'b0;
         end
         wait_cycles = $urandom_range(0, recv_gap_max);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : check_result
      tone_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tones.size() == 0) begin
            error_count++;
            $display("%0t: result with no transaction outstanding, frequency %0d",
                     $time, rsp_frequency_q16);
         end else begin
            want = expected_tones.pop_front();
            check_field("frequency_q16", longint'(want.frequency),
                        longint'(rsp_frequency_q16));
            check_field("midi_note", longint'(want.note), longint'(rsp_midi_note));
            check_field("pitch_class", longint'(want.pitch_class),
                        longint'(rsp_pitch_class));
            check_field("octave_now", longint'(want.octave), longint'(rsp_octave_now));
            check_field("cents_now", longint'(want.cents), longint'(rsp_cents_now));
            check_field("white_key", longint'(want.white), longint'(rsp_white_key));
            check_field("hue_q16", longint'(want.hue), longint'(rsp_hue_q16));
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (!reset && req_valid && req_stall)
         input_stall_cycles <= input_stall_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_tones.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int i;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = tnf_pkg::CMD_PLAY_NOTE;
      req_note    = 7'd0;
      req_amount  = 12'sd0;
      for (i = 0; i < tnf_pkg::PITCH_CLASSES; i++) class_cents[i] = 0;
      cur_note   = tnf_pkg::RESET_NOTE;
      cur_class  = 0;
      cur_octave = tnf_pkg::RESET_OCTAVE;
      cur_cents  = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_cases();
      test_random_traffic(450, 11, 11);
      test_random_traffic(300, 0, 0);
      test_result_backpressure();
      test_random_traffic(300, 3, 11);
      test_drain_pauses();
      test_random_traffic(250, 11, 0);

      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d commands and checked %0d results, directed extremes and random mixes",
               sent_count, checked_count);
      $display("Request side held off for %0d cycles by a full pipeline", input_stall_cycles);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
hdl/tnf_pkg.sv
hdl/tuned_note_to_frequency_unit.sv
test/tuned_note_to_frequency_unit_test.sv
